[design/enw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enw_pkg: shared types and constants for the number word parser
// word lexicon, prefix text, value widths and the word event passed between
// the word tracker and the accumulator
// ----------------------------------------------------------------------------
package enw_pkg;

    localparam int WORD_CHARS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CHAR_BITS  = 8;
    localparam int OUT_BITS   = 32;
    localparam int KEY_CHARS  = 9;
    localparam int KEY_BITS   = KEY_CHARS * CHAR_BITS;
    localparam int PREFIX_LEN = 8;
    localparam int SEEN_BITS  = 4;
    localparam int LEX_LEN_BITS = 4;
    localparam int ADD_BITS   = 7;
    localparam int LEX_COUNT  = 28;

    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'd13;

    localparam logic [PREFIX_LEN*CHAR_BITS-1:0] NEG_PREFIX = "negative";

    localparam logic [KEY_BITS-1:0] TXT_HUNDRED  = KEY_BITS'("hundred");
    localparam logic [KEY_BITS-1:0] TXT_THOUSAND = KEY_BITS'("thousand");
    localparam logic [KEY_BITS-1:0] TXT_MILLION  = KEY_BITS'("million");

    localparam logic [LEX_LEN_BITS-1:0] LEN_HUNDRED  = 4'd7;
    localparam logic [LEX_LEN_BITS-1:0] LEN_THOUSAND = 4'd8;
    localparam logic [LEX_LEN_BITS-1:0] LEN_MILLION  = 4'd7;

    localparam int MUL_HUNDRED  = 100;
    localparam int MUL_THOUSAND = 1000;
    localparam int MUL_MILLION  = 1000000;

    // key text is right aligned: last character in the low byte
    localparam logic [KEY_BITS-1:0] LEX_TEXT [LEX_COUNT] = '{
        KEY_BITS'("zero"),      KEY_BITS'("one"),       KEY_BITS'("two"),
        KEY_BITS'("three"),     KEY_BITS'("four"),      KEY_BITS'("five"),
        KEY_BITS'("six"),       KEY_BITS'("seven"),     KEY_BITS'("eight"),
        KEY_BITS'("nine"),      KEY_BITS'("ten"),       KEY_BITS'("eleven"),
        KEY_BITS'("twelve"),    KEY_BITS'("thirteen"),  KEY_BITS'("fourteen"),
        KEY_BITS'("fifteen"),   KEY_BITS'("sixteen"),   KEY_BITS'("seventeen"),
        KEY_BITS'("eighteen"),  KEY_BITS'("nineteen"),  KEY_BITS'("twenty"),
        KEY_BITS'("thirty"),    KEY_BITS'("forty"),     KEY_BITS'("fifty"),
        KEY_BITS'("sixty"),     KEY_BITS'("seventy"),   KEY_BITS'("eighty"),
        KEY_BITS'("ninety")
    };

    localparam logic [LEX_LEN_BITS-1:0] LEX_LEN [LEX_COUNT] = '{
        4'd4, 4'd3, 4'd3, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd5, 4'd4,
        4'd3, 4'd6, 4'd6, 4'd8, 4'd8, 4'd7, 4'd7, 4'd9, 4'd8, 4'd8,
        4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd7, 4'd6, 4'd6
    };

    localparam logic [ADD_BITS-1:0] LEX_VAL [LEX_COUNT] = '{
        7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
        7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19,
        7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
    };

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ADD,
        KIND_HUNDRED,
        KIND_THOUSAND,
        KIND_MILLION
    } word_kind_t;

    typedef struct packed {
        logic                fire;
        logic                line_end;
        logic                negate;
        word_kind_t          kind;
        logic [ADD_BITS-1:0] add;
    } word_event_t;

endpackage
`default_nettype wire

[design/enw_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enw_in_if: character channel
// one character of a text line per beat, with a last-character flag
// ----------------------------------------------------------------------------
interface enw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface
`default_nettype wire

[design/enw_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enw_out_if: number channel
// one signed 32-bit line value per beat
// ----------------------------------------------------------------------------
interface enw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] number_value;

    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface
`default_nettype wire

[design/enw_word.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enw_word: word tracker
// collects the current word into a shift key, matches it against the lexicon
// when it closes and follows the "negative" line prefix
// ----------------------------------------------------------------------------
module enw_word
    import enw_pkg::*;
#(
    parameter int WORD_CHARS = WORD_CHARS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic [CHAR_BITS-1:0] char_code,
    input  wire logic                 end_of_line,
    output word_event_t               ev
);

    localparam int LW = $clog2(WORD_CHARS + 1);

    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [LW-1:0]        len_reg, len_next;
    logic                 ovf_reg, ovf_next;
    logic [SEEN_BITS-1:0] seen_reg, seen_next;
    logic                 pre_reg, pre_next;

    logic [KEY_BITS-1:0]  eff_key;
    logic [LW-1:0]        eff_len;
    logic                 eff_ovf;
    logic                 sep;
    logic                 wfull;
    logic                 seen_lt;
    logic [CHAR_BITS-1:0] neg_byte;
    logic                 hit;
    logic [ADD_BITS-1:0]  hit_val;
    word_kind_t           kind;

    assign sep   = (char_code == CHAR_SPACE) ||
                   ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign wfull = (len_reg == LW'(WORD_CHARS));

    // word as it stands once this character is taken in
    always_comb
    begin
        if (sep)
        begin
            eff_key = key_reg;
            eff_len = len_reg;
            eff_ovf = ovf_reg;
        end
        else
        begin
            eff_key = {key_reg[KEY_BITS-CHAR_BITS-1:0], char_code};
            eff_len = wfull ? len_reg : len_reg + LW'(1);
            eff_ovf = ovf_reg | wfull;
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_val = '0;
        for (int i = 0; i < LEX_COUNT; i++)
        begin
            if ((eff_key == LEX_TEXT[i]) && (eff_len == LW'(LEX_LEN[i])))
            begin
                hit     = 1'b1;
                hit_val = LEX_VAL[i];
            end
        end
    end

    always_comb
    begin
        kind = KIND_NONE;
        if ((sep || end_of_line) && (eff_len != '0) && !eff_ovf)
        begin
            if ((eff_key == TXT_HUNDRED) && (eff_len == LW'(LEN_HUNDRED)))
                kind = KIND_HUNDRED;
            else if ((eff_key == TXT_THOUSAND) && (eff_len == LW'(LEN_THOUSAND)))
                kind = KIND_THOUSAND;
            else if ((eff_key == TXT_MILLION) && (eff_len == LW'(LEN_MILLION)))
                kind = KIND_MILLION;
            else if (hit)
                kind = KIND_ADD;
        end
    end

    // prefix check, one character per beat over the first eight
    assign seen_lt  = (seen_reg < SEEN_BITS'(PREFIX_LEN));
    assign neg_byte = NEG_PREFIX[CHAR_BITS * (3'(PREFIX_LEN - 1) - seen_reg[2:0]) +: CHAR_BITS];

    always_comb
    begin
        pre_next  = pre_reg & (!seen_lt || (char_code == neg_byte));
        seen_next = seen_lt ? seen_reg + SEEN_BITS'(1) : seen_reg;
    end

    always_comb
    begin
        if (end_of_line || sep)
        begin
            key_next = '0;
            len_next = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            key_next = eff_key;
            len_next = eff_len;
            ovf_next = eff_ovf;
        end
    end

    assign ev.fire     = fire;
    assign ev.line_end = end_of_line;
    assign ev.negate   = pre_next && !(seen_next < SEEN_BITS'(PREFIX_LEN));
    assign ev.kind     = kind;
    assign ev.add      = hit_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            seen_reg <= '0;
            pre_reg  <= 1'b1;
        end
        else if (fire)
        begin
            key_reg <= key_next;
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            if (end_of_line)
            begin
                seen_reg <= '0;
                pre_reg  <= 1'b1;
            end
            else
            begin
                seen_reg <= seen_next;
                pre_reg  <= pre_next;
            end
        end
    end

endmodule
`default_nettype wire

[design/enw_accum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enw_accum: group and line accumulator
// applies a closed word to the group sum and the line total
// ----------------------------------------------------------------------------
module enw_accum
    import enw_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  word_event_t                ev,
    output logic [VALUE_BITS-1:0]      line_total,
    output logic [VALUE_BITS-1:0]      group_sum
);

    logic [VALUE_BITS-1:0] group_reg, group_next;
    logic [VALUE_BITS-1:0] total_reg, total_next;
    logic [VALUE_BITS-1:0] g_add, g_hun, t_thou, t_mil;

    // all candidates side by side, the word kind picks one
    assign g_add  = group_reg + VALUE_BITS'(ev.add);
    assign g_hun  = group_reg * VALUE_BITS'(MUL_HUNDRED);
    assign t_thou = total_reg + group_reg * VALUE_BITS'(MUL_THOUSAND);
    assign t_mil  = total_reg + group_reg * VALUE_BITS'(MUL_MILLION);

    always_comb
    begin
        group_next = group_reg;
        total_next = total_reg;
        case (ev.kind)
            KIND_ADD:
                group_next = g_add;
            KIND_HUNDRED:
                group_next = g_hun;
            KIND_THOUSAND:
            begin
                total_next = t_thou;
                group_next = '0;
            end
            KIND_MILLION:
            begin
                total_next = t_mil;
                group_next = '0;
            end
            default:
            begin
                group_next = group_reg;
                total_next = total_reg;
            end
        endcase
    end

    assign line_total = total_next;
    assign group_sum  = group_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            total_reg <= '0;
        end
        else if (ev.fire)
        begin
            if (ev.line_end)
            begin
                group_reg <= '0;
                total_reg <= '0;
            end
            else
            begin
                group_reg <= group_next;
                total_reg <= total_next;
            end
        end
    end

endmodule
`default_nettype wire

[design/enw_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// enw_out: result stage
// holds the closing sums of a line, then adds them, negates the sum for a
// negative line and presents the 32-bit value on the number channel
// ----------------------------------------------------------------------------
module enw_out
    import enw_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  capture,
    input  wire logic                  negate,
    input  wire logic [VALUE_BITS-1:0] line_total,
    input  wire logic [VALUE_BITS-1:0] group_sum,
    output logic                       pend_free,
    enw_out_if.source                  numbers
);

    logic                  pend_vld_reg;
    logic [VALUE_BITS-1:0] pend_total_reg;
    logic [VALUE_BITS-1:0] pend_group_reg;
    logic                  pend_neg_reg;
    logic                  out_vld_reg;
    logic [OUT_BITS-1:0]   num_reg, num_next;
    logic [VALUE_BITS-1:0] sum;
    logic                  out_adv;

    assign out_adv   = !out_vld_reg || numbers.ready;
    assign pend_free = !pend_vld_reg || out_adv;

    assign sum      = pend_total_reg + pend_group_reg;
    assign num_next = pend_neg_reg ? OUT_BITS'(0) - sum[OUT_BITS-1:0] : sum[OUT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (pend_free)
                pend_vld_reg <= capture;
            if (out_adv)
                out_vld_reg <= pend_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_free && capture)
        begin
            pend_total_reg <= line_total;
            pend_group_reg <= group_sum;
            pend_neg_reg   <= negate;
        end
        if (out_adv && pend_vld_reg)
            num_reg <= num_next;
    end

    assign numbers.valid        = out_vld_reg;
    assign numbers.number_value = num_reg;

endmodule
`default_nettype wire

[design/english_number_words_to_integer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// english_number_words_to_integer_core: english number words to integer
// Parses a text line given one character per beat on the chars channel and
// returns the value of the line as one beat on the numbers channel.
//
// chars carries char_code and end_of_line; end_of_line marks the line's last
// character. Space, tab, LF, VT, FF and CR separate words. Words zero to
// nineteen and the tens add to a group, "hundred" scales it, "thousand" and
// "million" fold it into the line total; other words are skipped. A line
// opening with "negative" gives the negated sum. Values wrap at 32 bits.
//
// Throughput: one character per cycle, except when chars stalls as below.
// After the beat that carries end_of_line, the value passes through the input
// register, the line-end hold register and the output register.
// Reset clears all line state and both channels; the block then takes a
// character in the next cycle. When numbers is stalled, characters keep
// flowing and a finished line waits in the hold register; chars stalls only
// when a line end arrives while the output and hold registers are both full.
// ----------------------------------------------------------------------------
module english_number_words_to_integer_core
    import enw_pkg::*;
#(
    parameter int WORD_CHARS = WORD_CHARS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    enw_in_if.sink    chars,
    enw_out_if.source numbers
);

    logic                 in_vld_reg;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 eol_reg;
    logic                 proc;
    logic                 pend_free;

    word_event_t           ev;
    logic [VALUE_BITS-1:0] line_total;
    logic [VALUE_BITS-1:0] group_sum;

    // a line end moves on only if the hold register can take it
    assign proc        = in_vld_reg && (!eol_reg || pend_free);
    assign chars.ready = !in_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (chars.ready)
            in_vld_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            char_reg <= chars.char_code;
            eol_reg  <= chars.end_of_line;
        end
    end

    enw_word #(
        .WORD_CHARS (WORD_CHARS)
    ) u_word (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (proc),
        .char_code   (char_reg),
        .end_of_line (eol_reg),
        .ev          (ev)
    );

    enw_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev),
        .line_total (line_total),
        .group_sum  (group_sum)
    );

    enw_out #(
        .VALUE_BITS (VALUE_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (ev.fire && ev.line_end),
        .negate     (ev.negate),
        .line_total (line_total),
        .group_sum  (group_sum),
        .pend_free  (pend_free),
        .numbers    (numbers)
    );

endmodule
`default_nettype wire

[test/tb_english_number_words_to_integer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_english_number_words_to_integer_core: testbench for the number word parser
// Feeds text lines one character per beat on the chars channel and checks
// every line value on the numbers channel against its table value or a local
// line parser. A directed table covers lexicon words, the scaling words,
// separators, the negative prefix, overlong words and wrap-around; short
// lines back the block up against a long stall on the numbers side; random
// well-formed, broken and noise lines follow, both channels idling at random.
// ----------------------------------------------------------------------------
module tb_english_number_words_to_integer_core
    import enw_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 1650;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int WORD_LIMIT   = WORD_CHARS_DEF;
    localparam int NEG_LEN      = 8;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_VT = 8'd11;
    localparam logic [7:0] CHAR_FF = 8'd12;

    localparam string NEG_TEXT = "negative";

    typedef logic [7:0] byte_q_t [$];

    typedef struct {
        string       text;
        bit          known;
        logic [31:0] value;
    } line_case_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    enw_in_if  chars_if ();
    enw_out_if numbers_if ();

    english_number_words_to_integer_core DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .numbers (numbers_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // line parser state
    string       word_txt;
    int          word_len;
    bit          word_has_nul;
    bit          word_too_long;
    logic [31:0] group_val;
    logic [31:0] total_val;
    int          seen_count;
    bit          neg_match;

    logic [31:0] pending_values [$];
    line_case_t  directed_lines [$];

    int cycle_count   = 0;
    int error_count   = 0;
    int lines_checked = 0;
    int chars_sent    = 0;
    int send_idle_max = 8;
    int recv_idle_max = 8;
    bit hold_off_req  = 1'b0;

    function automatic string number_word(input int k);
        case (k)
            0:  return "zero";
            1:  return "one";
            2:  return "two";
            3:  return "three";
            4:  return "four";
            5:  return "five";
            6:  return "six";
            7:  return "seven";
            8:  return "eight";
            9:  return "nine";
            10: return "ten";
            11: return "eleven";
            12: return "twelve";
            13: return "thirteen";
            14: return "fourteen";
            15: return "fifteen";
            16: return "sixteen";
            17: return "seventeen";
            18: return "eighteen";
            19: return "nineteen";
            20: return "twenty";
            21: return "thirty";
            22: return "forty";
            23: return "fifty";
            24: return "sixty";
            25: return "seventy";
            26: return "eighty";
            default: return "ninety";
        endcase
    endfunction

    function automatic int word_number(input string w);
        int k;
        for (k = 0; k < 28; k++)
        begin
            if (number_word(k) == w)
                return (k < 20) ? k : (k - 18) * 10;
        end
        return -1;
    endfunction

    function automatic void clear_line_state();
        word_txt      = "";
        word_len      = 0;
        word_has_nul  = 1'b0;
        word_too_long = 1'b0;
        group_val     = '0;
        total_val     = '0;
        seen_count    = 0;
        neg_match     = 1'b1;
    endfunction

    function automatic void close_word();
        int v;
        // a word holding a nul byte can never be a number word
        if (word_len != 0 && !word_too_long && !word_has_nul)
        begin
            if (word_txt == "hundred")
                group_val = group_val * 32'd100;
            else if (word_txt == "thousand")
            begin
                total_val = total_val + group_val * 32'd1000;
                group_val = '0;
            end
            else if (word_txt == "million")
            begin
                total_val = total_val + group_val * 32'd1000000;
                group_val = '0;
            end
            else
            begin
                v = word_number(word_txt);
                if (v >= 0)
                    group_val = group_val + 32'(v);
            end
        end
        word_txt      = "";
        word_len      = 0;
        word_has_nul  = 1'b0;
        word_too_long = 1'b0;
    endfunction

    task automatic parse_char(input logic [7:0] c, input bit eol,
                              output bit produced, output logic [31:0] value);
        produced = 1'b0;
        value    = '0;
        if (seen_count < NEG_LEN)
        begin
            if (c != 8'(NEG_TEXT[seen_count]))
                neg_match = 1'b0;
            seen_count++;
        end
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
            close_word();
        else if (word_len < WORD_LIMIT)
        begin
            if (c == 8'd0)
                word_has_nul = 1'b1;
            else
                word_txt = {word_txt, string'(c)};
            word_len++;
        end
        else
            word_too_long = 1'b1;
        if (eol)
        begin
            close_word();
            value = total_val + group_val;
            if (neg_match && seen_count >= NEG_LEN)
                value = -value;
            produced = 1'b1;
            clear_line_state();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_number(input logic [31:0] got);
        logic [31:0] want;
        if (pending_values.size() == 0)
            report_mismatch($sformatf("unexpected number %0d", $signed(got)));
        else
        begin
            want = pending_values.pop_front();
            if (got !== want)
                report_mismatch($sformatf("line %0d: got %0d, expected %0d",
                                          lines_checked, $signed(got), $signed(want)));
        end
        lines_checked++;
    endtask

    task automatic drive_char(input logic [7:0] c, input bit eol);
        int gap;
        gap = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
        if (gap != 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid       <= 1'b1;
        chars_if.char_code   <= c;
        chars_if.end_of_line <= eol;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line(input byte_q_t line_bytes, input bit known,
                             input logic [31:0] known_val);
        bit          produced;
        logic [31:0] value;
        int          i;
        for (i = 0; i < line_bytes.size(); i++)
        begin
            parse_char(line_bytes[i], i == line_bytes.size() - 1, produced, value);
            if (produced)
                pending_values = {pending_values, (known ? known_val : value)};
            drive_char(line_bytes[i], i == line_bytes.size() - 1);
        end
    endtask

    function automatic void add_text(ref byte_q_t q, input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            q = {q, 8'(s[i])};
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 9))
            0:       return CHAR_TAB;
            1:       return CHAR_LF;
            2:       return CHAR_VT;
            3:       return CHAR_FF;
            4:       return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic string random_letters(input int lo, input int hi);
        string s;
        int    n;
        s = "";
        n = $urandom_range(lo, hi);
        repeat (n)
            s = {s, string'(8'($urandom_range(97, 122)))};
        return s;
    endfunction

    function automatic string pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return number_word($urandom_range(0, 27));
        else if (r < 75)
            return "hundred";
        else if (r < 83)
            return "thousand";
        else if (r < 90)
            return "million";
        else if (r < 95)
            return random_letters(1, 10);
        else if (r < 98)
            return random_letters(15, 20);
        else
            return NEG_TEXT;
    endfunction

    function automatic byte_q_t build_line();
        byte_q_t q;
        int      kind;
        int      n;
        int      k;
        int      at;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            // noise, leaning towards the byte extremes now and then
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0:       q = {q, 8'h00};
                    1:       q = {q, 8'hff};
                    default: q = {q, 8'($urandom_range(0, 255))};
                endcase
            end
            return q;
        end
        if ($urandom_range(0, 9) == 0)
            q = {q, pick_separator()};
        if ($urandom_range(0, 2) == 0)
        begin
            add_text(q, NEG_TEXT);
            q = {q, pick_separator()};
        end
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            if (k > 0)
                repeat ($urandom_range(1, 2)) q = {q, pick_separator()};
            add_text(q, pick_word());
        end
        if ($urandom_range(0, 4) == 0)
            q = {q, pick_separator()};
        if (kind >= 85)
        begin
            // broken line: damage one byte or cut the tail
            at = $urandom_range(0, q.size() - 1);
            if ($urandom_range(0, 1) == 1)
                q[at] = 8'($urandom_range(0, 255));
            else
                q = q[0:at];
        end
        return q;
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        add_text(q, s);
        return q;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // numbers side: random stalls per beat, one long hold on request
    initial
    begin
        int wait_n;
        numbers_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                numbers_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                wait_n = (recv_idle_max == 0) ? 0 : $urandom_range(0, recv_idle_max);
                if (wait_n != 0)
                begin
                    numbers_if.ready <= 1'b0;
                    repeat (wait_n) @(posedge clk);
                end
            end
            numbers_if.ready <= 1'b1;
            @(posedge clk);
            while (!numbers_if.valid)
                @(posedge clk);
            check_number(numbers_if.number_value);
        end
    end

    initial
    begin
        int i;
        chars_if.valid       <= 1'b0;
        chars_if.char_code   <= 8'd0;
        chars_if.end_of_line <= 1'b0;
        clear_line_state();

        directed_lines = '{
            '{"zero",                                  1'b1, 32'd0},
            '{"nineteen",                              1'b1, 32'd19},
            '{"negative one",                          1'b1, 32'hffff_ffff},
            '{"negative  two",                         1'b1, 32'hffff_fffe},
            '{"one hundred twenty three thousand four hundred fifty six",
                                                       1'b1, 32'd123456},
            '{"ninety nine million nine hundred ninety nine thousand nine hundred ninety nine",
                                                       1'b1, 32'd99999999},
            '{"two thousand million",                  1'b1, 32'd2000},
            '{"four thousand million hundred",         1'b1, 32'd4000},
            '{"negative",                              1'b1, 32'd0},
            '{"negativeone",                           1'b1, 32'd0},
            '{"negativ one",                           1'b1, 32'd1},
            '{"\011one\015two\012three\013four\014five\040", 1'b1, 32'd15},
            '{"abcdefghijklmnop three",                1'b1, 32'd3},
            '{"abcdefghijklmnopq three",               1'b1, 32'd3},
            '{"seventeenseventeen one",                1'b1, 32'd1},
            '{"forty two hundred hundred hundred hundred", 1'b1, 32'd4200000000},
            '{"negative forty two hundred hundred hundred hundred",
                                                       1'b1, 32'd94967296},
            '{"Zero one",                              1'b1, 32'd1},
            '{"\377 nine",                             1'b1, 32'd9},
            '{"\200\001 eight",                        1'b1, 32'd8},
            '{"a",                                     1'b1, 32'd0},
            '{" ",                                     1'b1, 32'd0},
            '{"twenty one hundred",                    1'b0, 32'd0},
            '{"eleven million twelve thousand thirteen", 1'b0, 32'd0},
            '{"negative sixty seven thousand",         1'b0, 32'd0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_lines.size(); i++)
            send_line(text_bytes(directed_lines[i].text), directed_lines[i].known,
                      directed_lines[i].value);

        // back-to-back short lines against a long stall on the numbers side
        send_idle_max = 0;
        hold_off_req  = 1'b1;
        repeat (30)
            send_line(text_bytes("one"), 1'b1, 32'd1);

        while (chars_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                send_idle_max = ($urandom_range(0, 1) == 1) ? 8 : 0;
            if ($urandom_range(0, 9) == 0)
                recv_idle_max = ($urandom_range(0, 1) == 1) ? 8 : 0;
            send_line(build_line(), 1'b0, 32'd0);
        end

        chars_if.valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[english_number_words_to_integer_core.f]
design/enw_pkg.sv
design/enw_in_if.sv
design/enw_out_if.sv
design/enw_word.sv
design/enw_accum.sv
design/enw_out.sv
design/english_number_words_to_integer_core.sv
test/tb_english_number_words_to_integer_core.sv
